// File: src/mpq_pkg.sv
// types, constants and the ranking function shared by the priority queue files
// no dependencies

package mpq_pkg;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_PEEK   = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;

   typedef struct packed {
      logic [15:0] roll;
      logic [15:0] marks;
      logic [15:0] tag;
   } rec_type;

   typedef struct packed {
      logic    is_empty;
      logic    dropped;
      rec_type top;
   } res_type;

   // true when a ranks strictly above b: larger marks, then lower roll
   function automatic logic ranks_above(input rec_type a, input rec_type b);
      logic res;
      if (a.marks != b.marks) begin
         res = (a.marks > b.marks);
      end else begin
         res = (a.roll < b.roll);
      end
      return res;
   endfunction

endpackage

// File: src/mpq_ifs.sv
// valid/ready channel interfaces for the command and result items
// no dependencies

interface mpq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] roll;
   logic [15:0] marks;
   logic [15:0] name_tag;

   modport source (output valid, mode, roll, marks, name_tag, input ready);
   modport sink   (input valid, mode, roll, marks, name_tag, output ready);
endinterface

interface mpq_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_empty;
   logic        dropped;
   logic [15:0] top_roll;
   logic [15:0] top_marks;
   logic [15:0] top_tag;

   modport source (output valid, is_empty, dropped, top_roll, top_marks, top_tag,
                   input ready);
   modport sink   (input valid, is_empty, dropped, top_roll, top_marks, top_tag,
                   output ready);
endinterface

// File: src/mpq_heap_mem.sv
// heap record store: one write port, two registered read ports
// depends on mpq_pkg

module mpq_heap_mem
   import mpq_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  rec_type       wr_data,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output rec_type       rd_data_a,
   output rec_type       rd_data_b
);

   rec_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// File: src/mpq_ctrl.sv
// heap sequencer: sift up on insert, sift down on remove, one level per read
// depends on mpq_pkg and on mpq_heap_mem through its ports

module mpq_ctrl
   import mpq_pkg::*;
#(
   parameter int CAPACITY = 256,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_valid,
   output logic          cmd_ready,
   input  logic [1:0]    cmd_mode,
   input  rec_type       cmd_rec,
   output logic          res_valid,
   input  logic          res_take,
   output res_type       res,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output rec_type       wr_data,
   output logic [AW-1:0] rd_addr_a,
   output logic [AW-1:0] rd_addr_b,
   input  rec_type       rd_data_a,
   input  rec_type       rd_data_b
);

   localparam int PW = AW + 2;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_UP    = 3'd1;
   localparam logic [2:0] S_UPCMP = 3'd2;
   localparam logic [2:0] S_LAST  = 3'd3;
   localparam logic [2:0] S_DOWN  = 3'd4;
   localparam logic [2:0] S_DNCMP = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] pos_ff, pos_in;
   rec_type       cur_ff, cur_in;
   rec_type       top_ff;
   logic          dropped_ff, dropped_in;

   logic [AW-1:0] pos_m1;
   logic [AW-1:0] parent;
   logic [PW-1:0] left_pos;
   logic [PW-1:0] right_pos;
   logic [PW-1:0] count_ext;
   logic [CW-1:0] count_m1;
   logic          right_ok;
   logic          pick_right;
   rec_type       best_rec;
   logic [PW-1:0] best_pos;

   assign pos_m1     = pos_ff - 1'b1;
   assign parent     = pos_m1 >> 1;
   assign left_pos   = {1'b0, pos_ff, 1'b1};
   assign right_pos  = left_pos + 1'b1;
   assign count_ext  = PW'(count_ff);
   assign count_m1   = count_ff - 1'b1;
   assign right_ok   = (right_pos < count_ext);
   assign pick_right = right_ok && ranks_above(rd_data_b, rd_data_a);
   assign best_rec   = pick_right ? rd_data_b : rd_data_a;
   assign best_pos   = pick_right ? right_pos : left_pos;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      cur_in     = cur_ff;
      dropped_in = dropped_ff;
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = cur_ff;
      rd_addr_a  = left_pos[AW-1:0];
      rd_addr_b  = right_pos[AW-1:0];
      cmd_ready  = (state_ff == S_IDLE);
      res_valid  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_mode)
                  MODE_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        dropped_in = 1'b1;
                        state_in   = S_DONE;
                     end else begin
                        dropped_in = 1'b0;
                        cur_in     = cmd_rec;
                        pos_in     = count_ff[AW-1:0];
                        count_in   = count_ff + 1'b1;
                        state_in   = S_UP;
                     end
                  end
                  MODE_PEEK: begin
                     dropped_in = 1'b0;
                     state_in   = S_DONE;
                  end
                  MODE_REMOVE: begin
                     dropped_in = 1'b0;
                     if (count_ff == '0) begin
                        state_in = S_DONE;
                     end else begin
                        count_in = count_m1;
                        if (count_m1 == '0) begin
                           state_in = S_DONE;
                        end else begin
                           rd_addr_a = count_m1[AW-1:0];
                           state_in  = S_LAST;
                        end
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_UP: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr_a = parent;
               state_in  = S_UPCMP;
            end
         end
         S_UPCMP: begin
            wr_en = 1'b1;
            if (ranks_above(cur_ff, rd_data_a)) begin
               wr_data  = rd_data_a;
               pos_in   = parent;
               state_in = S_UP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_LAST: begin
            cur_in   = rd_data_a;
            pos_in   = '0;
            state_in = S_DOWN;
         end
         S_DOWN: begin
            if (left_pos >= count_ext) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_DNCMP;
            end
         end
         S_DNCMP: begin
            wr_en = 1'b1;
            if (ranks_above(best_rec, cur_ff)) begin
               wr_data  = best_rec;
               pos_in   = best_pos[AW-1:0];
               state_in = S_DOWN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      cur_ff     <= cur_in;
      dropped_ff <= dropped_in;
      if (wr_en && (wr_addr == '0)) begin
         top_ff <= wr_data;
      end
   end

   always_comb begin
      res.is_empty = (count_ff == '0);
      res.dropped  = dropped_ff;
      res.top      = (count_ff == '0) ? '0 : top_ff;
   end

endmodule

// File: src/max_priority_queue_two_key_top.sv
// top level of the two-key max-priority queue: heap store, sequencer, result register
// depends on mpq_pkg, mpq_ifs, mpq_heap_mem and mpq_ctrl

// bounded max-priority queue of up to CAPACITY records (roll, marks, name tag) kept
// as a binary heap in one synchronous memory with a registered read. higher marks rank
// first, and on equal marks the lower roll. every command item yields one result item
// that reports the top record after the command; mode 3 is taken and yields nothing.
// one command is worked at a time. a peek, a refused insert or a remove that leaves
// the queue empty goes straight to the result. an insert climbs toward the root and a
// remove moves the last record to the root and sinks it; each level is one memory
// read (both children at once when sinking) followed by a compare and write back. at
// the default depth of 256 an insert that climbs all 8 levels sets the worst case.
// the result sits in an output register, so the next command may be accepted while
// that result waits to be taken; a further result then waits in the sequencer until
// the register frees. the store needs no clearing after reset: only entries below the
// entry count are ever used.

module max_priority_queue_two_key_top
   import mpq_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic      clock,
   input  logic      reset,
   mpq_req_if.sink   req_ch,
   mpq_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // memory port wiring
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   rec_type       wr_data;
   logic [AW-1:0] rd_addr_a;
   logic [AW-1:0] rd_addr_b;
   rec_type       rd_data_a;
   rec_type       rd_data_b;

   // sequencer to result register
   rec_type cmd_rec;
   logic    res_valid;
   logic    res_take;
   res_type res;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_data_ff;

   assign cmd_rec.roll  = req_ch.roll;
   assign cmd_rec.marks = req_ch.marks;
   assign cmd_rec.tag   = req_ch.name_tag;

   mpq_heap_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mpq_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_ch.valid),
      .cmd_ready (req_ch.ready),
      .cmd_mode  (req_ch.mode),
      .cmd_rec   (cmd_rec),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // the register is free when empty or when its item leaves this cycle
   assign res_take = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (res_valid && res_take) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.is_empty  = rsp_data_ff.is_empty;
   assign rsp_ch.dropped   = rsp_data_ff.dropped;
   assign rsp_ch.top_roll  = rsp_data_ff.top.roll;
   assign rsp_ch.top_marks = rsp_data_ff.top.marks;
   assign rsp_ch.top_tag   = rsp_data_ff.top.tag;

endmodule
